### rtl/assert_macros.svh
// assertion macros shared by the laser scan projector rtl
// no dependencies; included at the top of the core, cordic cell and scale files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked check, quiet while reset is asserted
`define LSP_ASSERT(name, ck, rstn, prop, msg) \
	name: assert property (@(posedge ck) disable iff (!rstn) prop) \
	else $error(msg);

// same check on the house clock and reset names
`define LSP_CHECK(name, prop, msg) \
	`LSP_ASSERT(name, clk, arst_n, prop, msg)

`endif

### rtl/lsp_pkg.sv
// shared types, constants and helper functions of the laser scan projector
// no dependencies; imported by every module of the block
package lsp_pkg;

	localparam int MAX_RAYS_DEF      = 4096;
	localparam int CORDIC_STAGES_DEF = 24;

	localparam int KEPT_TOTAL_W = 13;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 32;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_START_ANGLE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_STEP  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_ENABLE  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_RANGE   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_ENABLE  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_RANGE   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_INT_ENABLE  = 3'd6;

	// angle constants, q3.29 and q2.30
	localparam logic signed [33:0] PI_Q29      = 34'sd1686629713;
	localparam logic signed [33:0] TWO_PI_Q29  = 34'sd3373259426;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;

	localparam logic signed [31:0] ATAN_HEAD [11] = '{
		32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
		32'sd67021687, 32'sd33543516, 32'sd16775851, 32'sd8388437,
		32'sd4194283, 32'sd2097149, 32'sd1048576
	};

	// rotation vector handed from cell to cell, q2.30
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} cvec_t;

	// per-ray data that rides along the rotation chain
	typedef struct packed {
		logic signed [32:0]        mrange;    // range, negated when the angle was folded
		logic                      kept;
		logic [31:0]               intensity;
		logic                      last;
		logic [KEPT_TOTAL_W-1:0]   total;
	} side_t;

	// atan(2^-i) in q2.30; beyond the table it is 2^(30-i)
	function automatic logic signed [31:0] atan_entry(input int unsigned i);
		logic signed [31:0] r;
		if (i < 11) begin
			r = ATAN_HEAD[i[3:0]];
		end else begin
			r = 32'sd1 <<< (30 - i);
		end
		return r;
	endfunction

	// one correction pass is enough: inputs stay within one turn of [-pi, pi)
	function automatic logic signed [31:0] wrap_angle(input logic signed [33:0] a);
		logic signed [33:0] r;
		if (a >= PI_Q29) begin
			r = a - TWO_PI_Q29;
		end else if (a < -PI_Q29) begin
			r = a + TWO_PI_Q29;
		end else begin
			r = a;
		end
		return r[31:0];
	endfunction

endpackage

### rtl/laser_scan_polar_to_cartesian_core.sv
// laser scan projector: one range beat in, one cartesian point beat out
// a sample beat passes the front register, the cordic cells and the scale registers before point valid
// throughput: one beat per cycle; every stage advances whenever its successor has room
// reset: asynchronous, clears configuration, scan counters, angle accumulator and all valids
// no clearing pass after reset; samples are taken from the first cycle out of reset
// depends on lsp_pkg, lsp_cordic_cell, lsp_scale and assert_macros.svh
`include "assert_macros.svh"

module laser_scan_polar_to_cartesian_core #(
	parameter int MAX_RAYS      = lsp_pkg::MAX_RAYS_DEF,
	parameter int CORDIC_STAGES = lsp_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lsp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [lsp_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  logic signed [31:0]                  range_value,
	input  logic                                range_bad,
	input  logic [31:0]                         intensity_in,
	input  logic                                scan_last,
	output logic                                point_valid,
	input  logic                                point_ready,
	output logic signed [31:0]                  point_x,
	output logic signed [31:0]                  point_y,
	output logic [31:0]                         intensity_out,
	output logic                                point_kept,
	output logic                                scan_end,
	output logic [lsp_pkg::KEPT_TOTAL_W-1:0]    kept_total
);
	import lsp_pkg::*;

	localparam int CW = $clog2(MAX_RAYS + 1);
	localparam int TW = (CW > KEPT_TOTAL_W) ? CW : KEPT_TOTAL_W;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RAYS);

	// configuration
	logic signed [31:0] start_q;   // kept already wrapped to [-pi, pi)
	logic signed [31:0] step_q;
	logic signed [31:0] min_q;
	logic signed [31:0] max_q;
	logic               min_en_q;
	logic               max_en_q;
	logic               int_en_q;

	// scan state
	logic [CW-1:0]      ray_cnt_q;
	logic [CW-1:0]      kept_cnt_q;
	logic signed [31:0] acc_q;

	logic               sample_fire;
	logic signed [31:0] angle_cur;
	logic signed [33:0] angle_sum;
	logic signed [31:0] acc_next;
	logic               kept_now;
	logic [CW-1:0]      kept_next;
	logic [TW-1:0]      total_ext;

	// front register
	logic               valid_s1;
	logic signed [31:0] angle_s1;
	logic signed [31:0] range_s1;
	logic               kept_s1;
	logic [31:0]        inten_s1;
	logic               last_s1;
	logic [KEPT_TOTAL_W-1:0] total_s1;

	// fold into [-pi/2, pi/2]
	logic signed [33:0] z_full;
	logic signed [33:0] z_fold;
	logic               fold_neg;
	logic signed [32:0] range_ext;

	cvec_t  chain_vec   [CORDIC_STAGES+1];
	side_t  chain_side  [CORDIC_STAGES+1];
	logic   chain_valid [CORDIC_STAGES+1];
	logic   chain_ready [CORDIC_STAGES+1];

	side_t  out_side;

	// configuration port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			step_q   <= '0;
			min_q    <= '0;
			max_q    <= '0;
			min_en_q <= 1'b0;
			max_en_q <= 1'b0;
			int_en_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_START_ANGLE: start_q  <= wrap_angle(34'(signed'(cfg_data)));
				REG_ANGLE_STEP:  step_q   <= cfg_data;
				REG_MIN_ENABLE:  min_en_q <= cfg_data[0];
				REG_MIN_RANGE:   min_q    <= cfg_data;
				REG_MAX_ENABLE:  max_en_q <= cfg_data[0];
				REG_MAX_RANGE:   max_q    <= cfg_data;
				REG_INT_ENABLE:  int_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// per-ray angle, range checks and scan counters
	assign sample_fire = sample_valid && sample_ready;
	assign angle_cur   = (ray_cnt_q == '0) ? start_q : acc_q;
	assign angle_sum   = 34'(angle_cur) + 34'(step_q);
	assign acc_next    = wrap_angle(angle_sum);

	assign kept_now = !range_bad && !(min_en_q && (range_value < min_q))
		&& !(max_en_q && (range_value > max_q));
	assign kept_next = (kept_now && (kept_cnt_q < CNT_MAX)) ? kept_cnt_q + 1'b1 : kept_cnt_q;
	assign total_ext = TW'(kept_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_cnt_q  <= '0;
			kept_cnt_q <= '0;
			acc_q      <= '0;
		end else if (sample_fire) begin
			if (scan_last) begin
				ray_cnt_q  <= '0;
				kept_cnt_q <= '0;
				acc_q      <= '0;
			end else begin
				if (ray_cnt_q < CNT_MAX) begin
					ray_cnt_q <= ray_cnt_q + 1'b1;
				end
				kept_cnt_q <= kept_next;
				acc_q      <= acc_next;
			end
		end
	end

	assign sample_ready = !valid_s1 || chain_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_fire) begin
			angle_s1 <= angle_cur;
			range_s1 <= range_value;
			kept_s1  <= kept_now;
			inten_s1 <= (kept_now && int_en_q) ? intensity_in : 32'd0;
			last_s1  <= scan_last;
			total_s1 <= total_ext[KEPT_TOTAL_W-1:0];
		end
	end

	// q3.29 to q2.30, folded so the cordic converges; fold flips both outputs
	always_comb begin
		z_full   = {angle_s1[31], angle_s1, 1'b0};
		fold_neg = 1'b0;
		z_fold   = z_full;
		if (z_full > HALF_PI_Q30) begin
			z_fold   = z_full - PI_Q30;
			fold_neg = 1'b1;
		end else if (z_full < -HALF_PI_Q30) begin
			z_fold   = z_full + PI_Q30;
			fold_neg = 1'b1;
		end
		range_ext = 33'(range_s1);
	end

	assign chain_valid[0]       = valid_s1;
	assign chain_vec[0].x       = GAIN_Q30;
	assign chain_vec[0].y       = 32'sd0;
	assign chain_vec[0].z       = z_fold[31:0];
	assign chain_side[0].mrange = fold_neg ? -range_ext : range_ext;
	assign chain_side[0].kept   = kept_s1;
	assign chain_side[0].intensity = inten_s1;
	assign chain_side[0].last   = last_s1;
	assign chain_side[0].total  = total_s1;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		lsp_cordic_cell #(
			.STAGE(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[g]),
			.up_ready (chain_ready[g]),
			.up_vec   (chain_vec[g]),
			.up_side  (chain_side[g]),
			.dn_valid (chain_valid[g+1]),
			.dn_ready (chain_ready[g+1]),
			.dn_vec   (chain_vec[g+1]),
			.dn_side  (chain_side[g+1])
		);
	end

	lsp_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (chain_valid[CORDIC_STAGES]),
		.up_ready (chain_ready[CORDIC_STAGES]),
		.up_vec   (chain_vec[CORDIC_STAGES]),
		.up_side  (chain_side[CORDIC_STAGES]),
		.dn_valid (point_valid),
		.dn_ready (point_ready),
		.dn_x     (point_x),
		.dn_y     (point_y),
		.dn_side  (out_side)
	);

	assign intensity_out = out_side.intensity;
	assign point_kept    = out_side.kept;
	assign scan_end      = out_side.last;
	assign kept_total    = out_side.total;

	`LSP_CHECK(a_kept_le_rays, kept_cnt_q <= ray_cnt_q, "more points kept than rays seen")
	`LSP_CHECK(a_scan_end_clears, (sample_fire && scan_last) |=> (ray_cnt_q == '0 && kept_cnt_q == '0 && acc_q == 32'sd0), "scan state not cleared after last ray")
	`LSP_CHECK(a_acc_wrapped, (acc_q >= -PI_Q29) && (acc_q < PI_Q29), "angle accumulator left [-pi, pi)")

endmodule

### rtl/lsp_cordic_cell.sv
// one rotation cell of the cordic chain, with its own valid and ready
// depends on lsp_pkg and assert_macros.svh
`include "assert_macros.svh"

module lsp_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	output logic          up_ready,
	input  lsp_pkg::cvec_t up_vec,
	input  lsp_pkg::side_t up_side,
	output logic          dn_valid,
	input  logic          dn_ready,
	output lsp_pkg::cvec_t dn_vec,
	output lsp_pkg::side_t dn_side
);
	import lsp_pkg::*;

	logic               valid_q;
	cvec_t              vec_q;
	side_t              side_q;
	cvec_t              nxt;
	logic signed [31:0] dx;
	logic signed [31:0] dy;
	logic signed [31:0] ang;

	assign ang = atan_entry(STAGE);

	always_comb begin
		dx = up_vec.y >>> STAGE;
		dy = up_vec.x >>> STAGE;
		if (!up_vec.z[31]) begin
			nxt.x = up_vec.x - dx;
			nxt.y = up_vec.y + dy;
			nxt.z = up_vec.z - ang;
		end else begin
			nxt.x = up_vec.x + dx;
			nxt.y = up_vec.y - dy;
			nxt.z = up_vec.z + ang;
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			vec_q  <= nxt;
			side_q <= up_side;
		end
	end

	assign dn_valid = valid_q;
	assign dn_vec   = vec_q;
	assign dn_side  = side_q;

endmodule

### rtl/lsp_scale.sv
// scales the cordic cosine and sine by the range, rounds and saturates; a dropped ray gives a zero point
// depends on lsp_pkg and assert_macros.svh; two register stages, last one drives the ports
`include "assert_macros.svh"

module lsp_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  lsp_pkg::cvec_t       up_vec,
	input  lsp_pkg::side_t       up_side,
	output logic                dn_valid,
	input  logic                dn_ready,
	output logic signed [31:0]  dn_x,
	output logic signed [31:0]  dn_y,
	output lsp_pkg::side_t       dn_side
);
	import lsp_pkg::*;

	localparam logic signed [64:0] HALF_LSB = 65'sd536870912;
	localparam logic signed [64:0] SAT_HI   = 65'sd2147483647;
	localparam logic signed [64:0] SAT_LO   = -65'sd2147483648;

	logic               valid_s1;
	logic               valid_s2;
	logic               ready_s2;
	logic signed [64:0] prod_x_s1;
	logic signed [64:0] prod_y_s1;
	side_t              side_s1;
	side_t              side_s2;
	logic signed [31:0] x_s2;
	logic signed [31:0] y_s2;
	logic signed [31:0] x_rnd;
	logic signed [31:0] y_rnd;

	function automatic logic signed [31:0] round_sat(input logic signed [64:0] p);
		logic signed [64:0] s;
		logic signed [31:0] r;
		s = (p + HALF_LSB) >>> 30;
		if (s > SAT_HI) begin
			r = 32'sh7FFF_FFFF;
		end else if (s < SAT_LO) begin
			r = 32'sh8000_0000;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	assign ready_s2 = !valid_s2 || dn_ready;
	assign up_ready = !valid_s1 || ready_s2;

	assign x_rnd = side_s1.kept ? round_sat(prod_x_s1) : 32'sd0;
	assign y_rnd = side_s1.kept ? round_sat(prod_y_s1) : 32'sd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (up_ready) begin
				valid_s1 <= up_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			prod_x_s1 <= up_side.mrange * up_vec.x;
			prod_y_s1 <= up_side.mrange * up_vec.y;
			side_s1   <= up_side;
		end
		if (ready_s2 && valid_s1) begin
			x_s2    <= x_rnd;
			y_s2    <= y_rnd;
			side_s2 <= side_s1;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_x     = x_s2;
	assign dn_y     = y_s2;
	assign dn_side  = side_s2;

	`LSP_CHECK(a_drop_is_zero, (valid_s2 && !side_s2.kept) |-> (x_s2 == 32'sd0 && y_s2 == 32'sd0), "dropped ray carries a nonzero point")

endmodule
